/* rtl/core/lcd_four_bit_nibble_writer_assert.svh */
// Assertion macros shared by the checker of the LCD nibble writer.
`ifndef LCD_FOUR_BIT_NIBBLE_WRITER_ASSERT_SVH
`define LCD_FOUR_BIT_NIBBLE_WRITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCDNW_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCDNW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/lcdnw_pkg.sv */
// Types, constants and helper functions of the LCD nibble writer.
package lcdnw_pkg;

   localparam int MODE_W      = 2;
   localparam int BYTE_W      = 8;
   localparam int NIBBLE_W    = 4;
   localparam int WIDTH_US_W  = 16;
   localparam int WAIT_US_W   = 20;
   localparam int STEP_W      = 4;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 20;
   localparam int Q_DEPTH     = 2;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);
   localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_PULSE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_UP     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_FIRST  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_STEP   = 8'd3;

   localparam logic [WIDTH_US_W-1:0] ENABLE_PULSE_RESET = 16'd100;
   localparam logic [WAIT_US_W-1:0]  POWER_UP_RESET     = 20'd100000;
   localparam logic [WAIT_US_W-1:0]  RESET_FIRST_RESET  = 20'd100000;
   localparam logic [WIDTH_US_W-1:0] RESET_STEP_RESET   = 16'd200;
   localparam logic [WIDTH_US_W-1:0] MIN_ENABLE_WIDTH   = 16'd1;

   localparam logic [NIBBLE_W-1:0] RESET_NIBBLE      = 4'h3;
   localparam logic [NIBBLE_W-1:0] RESET_NIBBLE_LAST = 4'h2;

   localparam logic [STEP_W-1:0] LAST_STEP_BYTE  = 4'd1;
   localparam logic [STEP_W-1:0] LAST_STEP_RESET = 4'd3;
   localparam logic [STEP_W-1:0] LAST_STEP_INIT  = 4'd11;
   localparam logic [STEP_W-1:0] FIRST_CMD_STEP  = 4'd4;

   typedef enum logic [MODE_W-1:0] {
      OP_CMD   = 2'd0,
      OP_DATA  = 2'd1,
      OP_RESET = 2'd2,
      OP_INIT  = 2'd3
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [BYTE_W-1:0]   byte_value;
      logic [STEP_W-1:0]   last_step;
   } q_entry_type;

   typedef struct packed {
      logic [WIDTH_US_W-1:0] enable_pulse_us;
      logic [WAIT_US_W-1:0]  power_up_wait_us;
      logic [WAIT_US_W-1:0]  reset_first_wait_us;
      logic [WIDTH_US_W-1:0] reset_step_wait_us;
   } cfg_type;

   typedef struct packed {
      logic [NIBBLE_W-1:0]   nibble;
      logic                  register_select;
      logic [WIDTH_US_W-1:0] enable_width_us;
      logic [WAIT_US_W-1:0]  wait_before_us;
      logic [WAIT_US_W-1:0]  wait_after_us;
      logic                  last;
   } strobe_type;

   function automatic logic [BYTE_W-1:0] init_cmd(input logic [1:0] idx);
      logic [BYTE_W-1:0] cmd;
      unique case (idx)
         2'd0:    cmd = 8'h28;
         2'd1:    cmd = 8'h0E;
         2'd2:    cmd = 8'h01;
         default: cmd = 8'h80;
      endcase
      return cmd;
   endfunction

endpackage

/* rtl/core/lcdnw_front.sv */
// Front end: accepts operations and classifies them for the strobe sequencer.
module lcdnw_front
   import lcdnw_pkg::*;
(
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [BYTE_W-1:0]   req_byte,
   input  logic                q_full,
   output logic                q_push,
   output q_entry_type         q_entry
);

   op_type op;

   always_comb begin
      op = op_type'(req_mode);
      q_entry.op         = op;
      q_entry.byte_value = req_byte;
      unique case (op)
         OP_CMD, OP_DATA: q_entry.last_step = LAST_STEP_BYTE;
         OP_RESET:        q_entry.last_step = LAST_STEP_RESET;
         default:         q_entry.last_step = LAST_STEP_INIT;
      endcase
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

endmodule

/* rtl/core/lcdnw_queue.sv */
// Short queue of classified operations between the front end and the sequencer.
module lcdnw_queue
   import lcdnw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   output logic        full,
   input  logic        pop,
   output logic        head_valid,
   output q_entry_type head_entry
);

   q_entry_type          entries_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full       = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/core/lcdnw_back.sv */
// Back end: steps through the strobes of the queued operation into the output register.
module lcdnw_back
   import lcdnw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        head_valid,
   input  q_entry_type head_entry,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output strobe_type  rsp_strobe
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] cmd_step;
   logic              out_valid_ff, out_valid_in;
   strobe_type        out_ff;
   strobe_type        strobe;
   logic              load;
   logic [BYTE_W-1:0] cmd_byte;

   assign load     = head_valid && (!out_valid_ff || rsp_ready);
   assign cmd_step = step_ff - FIRST_CMD_STEP;
   assign cmd_byte = init_cmd(cmd_step[2:1]);

   always_comb begin
      strobe.register_select = 1'b0;
      strobe.wait_before_us  = '0;
      strobe.wait_after_us   = '0;
      strobe.enable_width_us = (cfg.enable_pulse_us == '0) ? MIN_ENABLE_WIDTH
                                                            : cfg.enable_pulse_us;
      strobe.last            = (step_ff == head_entry.last_step);
      unique case (head_entry.op)
         OP_CMD, OP_DATA: begin
            strobe.register_select = (head_entry.op == OP_DATA);
            strobe.nibble = step_ff[0] ? head_entry.byte_value[3:0]
                                       : head_entry.byte_value[7:4];
         end
         default: begin
            if (step_ff < FIRST_CMD_STEP) begin
               strobe.nibble = (step_ff == LAST_STEP_RESET) ? RESET_NIBBLE_LAST
                                                            : RESET_NIBBLE;
               if (step_ff == '0) begin
                  strobe.wait_after_us = cfg.reset_first_wait_us;
                  if (head_entry.op == OP_INIT) begin
                     strobe.wait_before_us = cfg.power_up_wait_us;
                  end
               end else begin
                  strobe.wait_after_us = WAIT_US_W'(cfg.reset_step_wait_us);
               end
            end else begin
               strobe.nibble = step_ff[0] ? cmd_byte[3:0] : cmd_byte[7:4];
            end
         end
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      pop          = 1'b0;
      if (load) begin
         out_valid_in = 1'b1;
         if (strobe.last) begin
            step_in = '0;
            pop     = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= strobe;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_strobe = out_ff;

endmodule

/* rtl/core/lcd_four_bit_nibble_writer.sv */
// Top level of the 4-bit character LCD nibble writer.
// Each accepted operation is turned into a run of enable strobes, one result per strobe:
// a command or data write gives two, the reset sequence four and the full init twelve.
// The sequencer emits one strobe per clock cycle unless the output transfer is stalled,
// and a two-entry queue lets new operations be taken while the current run is still
// being emitted or its output transfer is stalled. The timing registers are read as
// each strobe is formed and should be written only while idle.
module lcd_four_bit_nibble_writer
   import lcdnw_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // byte_value[7:0]
   input  logic [1:0]              req_tuser,   // mode[1:0]
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [63:0]             rsp_tdata,   // nibble[3:0], enable_width_us[19:4],
                                                // wait_before_us[39:20], wait_after_us[59:40],
                                                // zero[63:60]
   output logic                    rsp_tuser,   // register_select[0]
   output logic                    rsp_tlast,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   cfg_type     cfg_ff, cfg_in;
   logic        q_full, q_push, q_pop, head_valid;
   q_entry_type push_entry, head_entry;
   strobe_type  strobe;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE_PULSE: cfg_in.enable_pulse_us     = csr_data[WIDTH_US_W-1:0];
            CSR_POWER_UP:     cfg_in.power_up_wait_us    = csr_data;
            CSR_RESET_FIRST:  cfg_in.reset_first_wait_us = csr_data;
            CSR_RESET_STEP:   cfg_in.reset_step_wait_us  = csr_data[WIDTH_US_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_pulse_us     <= ENABLE_PULSE_RESET;
         cfg_ff.power_up_wait_us    <= POWER_UP_RESET;
         cfg_ff.reset_first_wait_us <= RESET_FIRST_RESET;
         cfg_ff.reset_step_wait_us  <= RESET_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcdnw_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .req_byte   (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   lcdnw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   lcdnw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_strobe (strobe)
   );

   assign rsp_tdata = {4'b0000, strobe.wait_after_us, strobe.wait_before_us,
                       strobe.enable_width_us, strobe.nibble};
   assign rsp_tuser = strobe.register_select;
   assign rsp_tlast = strobe.last;

endmodule

/* rtl/core/lcdnw_checker.sv */
// Port-level checker of the LCD nibble writer and its bind to the top level.
`include "lcd_four_bit_nibble_writer_assert.svh"

module lcdnw_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast
);

   // A stalled strobe must keep its contents until the transfer completes.
   `LCDNW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled strobe changed")

   // The enable width is never zero.
   `LCDNW_ASSERT_SAME(a_enable_nonzero, clock, reset, rsp_tvalid, rsp_tdata[19:4] != 16'd0, "zero enable width")

   // Data strobes never carry waits.
   `LCDNW_ASSERT_SAME(a_data_no_wait, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[59:20] == 40'd0, "data strobe with wait")

   // The high nibble of a data byte is followed at once by its low nibble.
   `LCDNW_ASSERT_NEXT(a_data_pair, clock, reset, rsp_tvalid && rsp_tready && rsp_tuser && !rsp_tlast, rsp_tvalid && rsp_tuser && rsp_tlast, "data byte split")

endmodule

bind lcd_four_bit_nibble_writer lcdnw_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

/* verif/tb_top.sv */
// Self-checking testbench for the 4-bit LCD nibble writer: operations in, strobes checked.
module tb_top
   import lcdnw_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PHASES     = 5;
   localparam int OPS_PER_PHASE  = 40;
   localparam int NUM_DIRECTED   = 20;
   localparam int IDLE_LIMIT     = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_TOP = 8'hFF;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LOW = 8'd4;
   localparam logic [BYTE_W-1:0] INIT_SEQUENCE [4] = '{8'h28, 8'h0E, 8'h01, 8'h80};

   typedef struct packed {
      op_type              op;
      logic [BYTE_W-1:0]   byte_value;
      logic                typed;
      logic [NIBBLE_W-1:0] hi;
      logic [NIBBLE_W-1:0] lo;
   } op_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;
   logic [1:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [63:0]            rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   cfg_type    timing;
   strobe_type expected_strobes [$];
   op_row_type directed_ops [NUM_DIRECTED];
   logic [CSR_DATA_W-1:0] phase_settings [3][4];
   int         req_idle_pct = 15;
   int         rsp_idle_pct = 70;
   int         mismatches = 0;
   int         idle_cycles = 0;

   lcd_four_bit_nibble_writer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void add_strobe(logic [NIBBLE_W-1:0] nib, logic rs,
                                      logic [WAIT_US_W-1:0] wait_before,
                                      logic [WAIT_US_W-1:0] wait_after, logic is_last);
      strobe_type s;
      s.nibble          = nib;
      s.register_select = rs;
      s.enable_width_us = (timing.enable_pulse_us == '0) ? 16'd1 : timing.enable_pulse_us;
      s.wait_before_us  = wait_before;
      s.wait_after_us   = wait_after;
      s.last            = is_last;
      expected_strobes.push_back(s);
   endfunction

   function automatic void add_byte(logic [BYTE_W-1:0] b, logic rs, logic is_last);
      add_strobe(b[7:4], rs, '0, '0, 1'b0);
      add_strobe(b[3:0], rs, '0, '0, is_last);
   endfunction

   function automatic void expand_op(op_type op, logic [BYTE_W-1:0] b);
      logic [WAIT_US_W-1:0] wait_before;
      logic [WAIT_US_W-1:0] wait_after;
      case (op)
         OP_CMD:  add_byte(b, 1'b0, 1'b1);
         OP_DATA: add_byte(b, 1'b1, 1'b1);
         default: begin
            for (int i = 0; i < 4; i++) begin
               wait_before = (i == 0 && op == OP_INIT) ? timing.power_up_wait_us : '0;
               wait_after  = (i == 0) ? timing.reset_first_wait_us
                                      : WAIT_US_W'(timing.reset_step_wait_us);
               add_strobe((i == 3) ? RESET_NIBBLE_LAST : RESET_NIBBLE, 1'b0,
                          wait_before, wait_after, op == OP_RESET && i == 3);
            end
            if (op == OP_INIT) begin
               for (int i = 0; i < 4; i++)
                  add_byte(INIT_SEQUENCE[i], 1'b0, i == 3);
            end
         end
      endcase
   endfunction

   function automatic void apply_csr_write(logic [CSR_INDEX_W-1:0] index,
                                          logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_ENABLE_PULSE: timing.enable_pulse_us     = data[15:0];
         CSR_POWER_UP:     timing.power_up_wait_us    = data;
         CSR_RESET_FIRST:  timing.reset_first_wait_us = data;
         CSR_RESET_STEP:   timing.reset_step_wait_us  = data[15:0];
         default: ;
      endcase
   endfunction

   task automatic push_op(op_type op, logic [BYTE_W-1:0] b);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr_write(index, data);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_strobes.size() != 0);
   endtask

   task automatic check_field(string name, logic [WAIT_US_W-1:0] exp_v,
                              logic [WAIT_US_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      strobe_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_strobes.size() == 0) begin
            $error("strobe transfer with no expectation pending: tdata 0x%0h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_strobes.pop_front();
            check_field("nibble", WAIT_US_W'(want.nibble), WAIT_US_W'(rsp_tdata[3:0]));
            check_field("register_select", WAIT_US_W'(want.register_select),
                        WAIT_US_W'(rsp_tuser));
            check_field("enable_width_us", WAIT_US_W'(want.enable_width_us),
                        WAIT_US_W'(rsp_tdata[19:4]));
            check_field("wait_before_us", want.wait_before_us, rsp_tdata[39:20]);
            check_field("wait_after_us", want.wait_after_us, rsp_tdata[59:40]);
            check_field("last", WAIT_US_W'(want.last), WAIT_US_W'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      op_row_type            row;
      op_type                op;
      logic [CSR_DATA_W-1:0] data;

      timing.enable_pulse_us     = ENABLE_PULSE_RESET;
      timing.power_up_wait_us    = POWER_UP_RESET;
      timing.reset_first_wait_us = RESET_FIRST_RESET;
      timing.reset_step_wait_us  = RESET_STEP_RESET;

      directed_ops = '{
         '{OP_CMD,   8'h00, 1'b1, 4'h0, 4'h0},
         '{OP_CMD,   8'hFF, 1'b1, 4'hF, 4'hF},
         '{OP_DATA,  8'h00, 1'b1, 4'h0, 4'h0},
         '{OP_DATA,  8'hFF, 1'b1, 4'hF, 4'hF},
         '{OP_DATA,  8'hA5, 1'b1, 4'hA, 4'h5},
         '{OP_CMD,   8'h5A, 1'b1, 4'h5, 4'hA},
         '{OP_RESET, 8'h00, 1'b0, 4'h0, 4'h0},
         '{OP_INIT,  8'h00, 1'b0, 4'h0, 4'h0},
         '{OP_RESET, 8'hFF, 1'b0, 4'h0, 4'h0},
         '{OP_INIT,  8'hFF, 1'b0, 4'h0, 4'h0},
         '{OP_CMD,   8'h28, 1'b1, 4'h2, 4'h8},
         '{OP_CMD,   8'h0E, 1'b1, 4'h0, 4'hE},
         '{OP_CMD,   8'h01, 1'b1, 4'h0, 4'h1},
         '{OP_CMD,   8'h80, 1'b1, 4'h8, 4'h0},
         '{OP_DATA,  8'h41, 1'b1, 4'h4, 4'h1},
         '{OP_DATA,  8'h7E, 1'b1, 4'h7, 4'hE},
         '{OP_INIT,  8'h3C, 1'b0, 4'h0, 4'h0},
         '{OP_CMD,   8'h0F, 1'b1, 4'h0, 4'hF},
         '{OP_DATA,  8'h80, 1'b1, 4'h8, 4'h0},
         '{OP_DATA,  8'h01, 1'b1, 4'h0, 4'h1}
      };

      // A zero enable width, all-ones values that overflow the 16-bit registers,
      // then the smallest widths with stray upper bits.
      phase_settings = '{
         '{20'h00000, 20'h00000, 20'h00000, 20'h00000},
         '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF},
         '{20'hF0001, 20'h00001, 20'h80000, 20'h10007}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_ops[i]) begin
         row = directed_ops[i];
         push_op(row.op, row.byte_value);
         if (row.typed) begin
            expected_strobes.push_back(strobe_type'{row.hi, row.op == OP_DATA,
                                                    ENABLE_PULSE_RESET, '0, '0, 1'b0});
            expected_strobes.push_back(strobe_type'{row.lo, row.op == OP_DATA,
                                                    ENABLE_PULSE_RESET, '0, '0, 1'b1});
         end else begin
            expand_op(row.op, row.byte_value);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain();
         req_idle_pct = (phase < 2) ? 15 : (phase < 4) ? 70 : 0;
         rsp_idle_pct = (phase < 2) ? 70 : (phase < 4) ? 15 : 0;
         for (int r = 0; r < 4; r++) begin
            data = (phase < 3) ? phase_settings[phase][r] : CSR_DATA_W'($urandom);
            write_csr(CSR_INDEX_W'(r), data);
         end
         write_csr((phase == 0) ? CSR_UNUSED_TOP
                                : CSR_INDEX_W'($urandom_range(CSR_UNUSED_LOW, CSR_UNUSED_TOP)),
                   CSR_DATA_W'($urandom));
         csr_valid <= 1'b0;
         for (int i = 0; i < OPS_PER_PHASE; i++) begin
            if (i == OPS_PER_PHASE / 2)
               drain();
            case ($urandom_range(0, 9))
               0, 1, 2, 3: op = OP_CMD;
               4, 5, 6, 7: op = OP_DATA;
               8:          op = OP_RESET;
               default:    op = OP_INIT;
            endcase
            data = CSR_DATA_W'($urandom_range(0, 255));
            push_op(op, data[BYTE_W-1:0]);
            expand_op(op, data[BYTE_W-1:0]);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_strobes.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
